// ===== design/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants and types for the touch pressure and pen-up filter.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int SCALE_BITS     = 12;
    localparam int CNT_BITS       = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CNT_BITS-1:0] CNT_MAX = 4'd15;

    localparam logic [SCALE_BITS-1:0] X_SCALE_RESET   = 12'd480;
    localparam logic [SCALE_BITS-1:0] Y_SCALE_RESET   = 12'd272;
    localparam logic [CNT_BITS-1:0]   THRESHOLD_RESET = 4'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_SCALE         = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_SCALE         = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PENUP_THRESHOLD = 2'd2;

    // item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PENUP  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MULA   = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_MULB   = 6'b001000,
        ST_SAT    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

endpackage

// ===== design/tpf_in_if.sv =====
// ----------------------------------------------------------------------------
// tpf_in_if
// Input channel: touch sample or pen-up event with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpf_in_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [SAMPLE_BITS-1:0] pos_x;
    logic [SAMPLE_BITS-1:0] pos_y;
    logic [SAMPLE_BITS-1:0] z_one;
    logic [SAMPLE_BITS-1:0] z_two;
    logic                   use_x_axis;

    modport source (output valid, output operation, output pos_x, output pos_y,
                    output z_one, output z_two, output use_x_axis, input ready);
    modport sink   (input valid, input operation, input pos_x, input pos_y,
                    input z_one, input z_two, input use_x_axis, output ready);
endinterface

// ===== design/tpf_out_if.sv =====
// ----------------------------------------------------------------------------
// tpf_out_if
// Output channel: touch report with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpf_out_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] out_x;
    logic [SAMPLE_BITS-1:0] out_y;
    logic [SAMPLE_BITS-1:0] pressure;
    logic                   touching;

    modport source (output valid, output out_x, output out_y, output pressure,
                    output touching, input ready);
    modport sink   (input valid, input out_x, input out_y, input pressure,
                    input touching, output ready);
endinterface

// ===== design/touch_pressure_and_penup_filter.sv =====
// ----------------------------------------------------------------------------
// touch_pressure_and_penup_filter
// Resistive touch pressure from x/y/z1/z2 samples plus pen-up release filter.
// ----------------------------------------------------------------------------
// A sample needing the pressure formula goes through MULA, DIVIDE, MULB, SAT
//   and DONE before its report is loaded; other reports go from idle straight to DONE.
// Input is ready only while the sequencer idles, so a new item is not taken until
//   the previous one has left DONE; a silent pen-up leaves the sequencer idle.
// The output register holds a report while the next item is taken.
// Reset: asynchronous, active low; scales and threshold load defaults, counter clears.
// ----------------------------------------------------------------------------
module touch_pressure_and_penup_filter #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    tpf_in_if.sink                               in_ch,
    tpf_out_if.source                            out_ch,
    input  logic                                 cfg_we,
    input  logic [tpf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tpf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int S  = SAMPLE_BITS;
    localparam int W  = tpf_pkg::SCALE_BITS + SAMPLE_BITS;
    localparam int CW = $clog2(W + 1);
    localparam int SB = tpf_pkg::SCALE_BITS;
    localparam int NB = tpf_pkg::CNT_BITS;

    localparam logic [S-1:0] SMAX = {S{1'b1}};

    tpf_pkg::state_t state_reg, state_next;

    logic [SB-1:0] x_scale_reg, x_scale_next;
    logic [SB-1:0] y_scale_reg, y_scale_next;
    logic [NB-1:0] threshold_reg, threshold_next;
    logic [NB-1:0] penup_cnt_reg, penup_cnt_next;
    logic          release_reported_reg, release_reported_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic          out_valid_reg, out_valid_next;

    logic [SB-1:0]  scale_reg, scale_next;
    logic [S-1:0]   coord_reg, coord_next;
    logic [S-1:0]   z1_reg, z1_next;
    logic [S-1:0]   z2_reg, z2_next;
    logic [W-1:0]   quot_reg, quot_next;
    logic [S-1:0]   rem_reg, rem_next;
    logic [W+S-1:0] prod_reg, prod_next;
    logic [S-1:0]   res_x_reg, res_x_next;
    logic [S-1:0]   res_y_reg, res_y_next;
    logic [S-1:0]   res_p_reg, res_p_next;
    logic           res_touch_reg, res_touch_next;
    logic [S-1:0]   out_x_reg, out_x_next;
    logic [S-1:0]   out_y_reg, out_y_next;
    logic [S-1:0]   out_p_reg, out_p_next;
    logic           out_touch_reg, out_touch_next;

    logic           in_fire;
    logic           out_load;
    logic [W-1:0]   mul_a;
    logic [S-1:0]   mul_b;
    logic [W+S-1:0] mul_p;
    logic [S:0]     trial;
    logic [S:0]     trial_diff;
    logic           trial_ge;
    logic [W-1:0]   p_full;
    logic [S-1:0]   p_sat;
    logic [NB-1:0]  cnt_inc;

    assign in_ch.ready     = (state_reg == tpf_pkg::ST_IDLE);
    assign in_fire         = in_ch.valid && in_ch.ready;
    assign out_load        = (state_reg == tpf_pkg::ST_DONE) && (!out_valid_reg || out_ch.ready);

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_x    = out_x_reg;
    assign out_ch.out_y    = out_y_reg;
    assign out_ch.pressure = out_p_reg;
    assign out_ch.touching = out_touch_reg;

    // shared multiplier: scale*z2 first, then (ratio-scale)*coord
    always_comb
    begin
        if (state_reg == tpf_pkg::ST_MULA)
        begin
            mul_a = W'(scale_reg);
            mul_b = z2_reg;
        end
        else
        begin
            mul_a = quot_reg - W'(scale_reg);
            mul_b = coord_reg;
        end
        mul_p = (W+S)'(mul_a) * (W+S)'(mul_b);
    end

    // one restoring-division step
    assign trial      = {rem_reg, quot_reg[W-1]};
    assign trial_diff = trial - {1'b0, z1_reg};
    assign trial_ge   = (trial >= {1'b0, z1_reg});

    // drop the fraction and saturate
    assign p_full = prod_reg[W+S-1:S];
    assign p_sat  = (|p_full[W-1:S]) ? SMAX : p_full[S-1:0];

    assign cnt_inc = (penup_cnt_reg == tpf_pkg::CNT_MAX) ? penup_cnt_reg
                                                        : penup_cnt_reg + 1'b1;

    always_comb
    begin
        state_next            = state_reg;
        x_scale_next          = x_scale_reg;
        y_scale_next          = y_scale_reg;
        threshold_next        = threshold_reg;
        penup_cnt_next        = penup_cnt_reg;
        release_reported_next = release_reported_reg;
        bit_cnt_next          = bit_cnt_reg;
        scale_next            = scale_reg;
        coord_next            = coord_reg;
        z1_next               = z1_reg;
        z2_next               = z2_reg;
        quot_next             = quot_reg;
        rem_next              = rem_reg;
        prod_next             = prod_reg;
        res_x_next            = res_x_reg;
        res_y_next            = res_y_reg;
        res_p_next            = res_p_reg;
        res_touch_next        = res_touch_reg;
        out_x_next            = out_x_reg;
        out_y_next            = out_y_reg;
        out_p_next            = out_p_reg;
        out_touch_next        = out_touch_reg;
        out_valid_next        = out_valid_reg && !out_ch.ready;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tpf_pkg::CFG_X_SCALE:         x_scale_next   = cfg_data[SB-1:0];
                tpf_pkg::CFG_Y_SCALE:         y_scale_next   = cfg_data[SB-1:0];
                tpf_pkg::CFG_PENUP_THRESHOLD: threshold_next = cfg_data[NB-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            tpf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.operation == tpf_pkg::OP_SAMPLE)
                    begin
                        penup_cnt_next        = '0;
                        release_reported_next = 1'b0;
                        scale_next     = in_ch.use_x_axis ? x_scale_reg : y_scale_reg;
                        coord_next     = in_ch.use_x_axis ? in_ch.pos_x : in_ch.pos_y;
                        z1_next        = in_ch.z_one;
                        z2_next        = in_ch.z_two;
                        res_x_next     = in_ch.pos_x;
                        res_y_next     = in_ch.pos_y;
                        res_touch_next = 1'b1;
                        if (in_ch.z_one == '0)
                        begin
                            res_p_next = SMAX;
                            state_next = tpf_pkg::ST_DONE;
                        end
                        else if (in_ch.z_one > in_ch.z_two)
                        begin
                            res_p_next = '0;
                            state_next = tpf_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = tpf_pkg::ST_MULA;
                        end
                    end
                    else if (!release_reported_reg)
                    begin
                        penup_cnt_next = cnt_inc;
                        if (cnt_inc >= threshold_reg)
                        begin
                            release_reported_next = 1'b1;
                            res_x_next     = '0;
                            res_y_next     = '0;
                            res_p_next     = '0;
                            res_touch_next = 1'b0;
                            state_next     = tpf_pkg::ST_DONE;
                        end
                    end
                end
            end
            tpf_pkg::ST_MULA:
            begin
                quot_next    = mul_p[W-1:0];
                rem_next     = '0;
                bit_cnt_next = '0;
                state_next   = tpf_pkg::ST_DIVIDE;
            end
            tpf_pkg::ST_DIVIDE:
            begin
                quot_next    = {quot_reg[W-2:0], trial_ge};
                rem_next     = trial_ge ? trial_diff[S-1:0] : trial[S-1:0];
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CW'(W - 1))
                begin
                    state_next = tpf_pkg::ST_MULB;
                end
            end
            tpf_pkg::ST_MULB:
            begin
                prod_next  = mul_p;
                state_next = tpf_pkg::ST_SAT;
            end
            tpf_pkg::ST_SAT:
            begin
                res_p_next = SMAX - p_sat;
                state_next = tpf_pkg::ST_DONE;
            end
            tpf_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_p_next     = res_p_reg;
                    out_touch_next = res_touch_reg;
                    state_next     = tpf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= tpf_pkg::ST_IDLE;
            x_scale_reg          <= tpf_pkg::X_SCALE_RESET;
            y_scale_reg          <= tpf_pkg::Y_SCALE_RESET;
            threshold_reg        <= tpf_pkg::THRESHOLD_RESET;
            penup_cnt_reg        <= '0;
            release_reported_reg <= 1'b0;
            bit_cnt_reg          <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            x_scale_reg          <= x_scale_next;
            y_scale_reg          <= y_scale_next;
            threshold_reg        <= threshold_next;
            penup_cnt_reg        <= penup_cnt_next;
            release_reported_reg <= release_reported_next;
            bit_cnt_reg          <= bit_cnt_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scale_reg     <= scale_next;
        coord_reg     <= coord_next;
        z1_reg        <= z1_next;
        z2_reg        <= z2_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        prod_reg      <= prod_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_p_reg     <= res_p_next;
        res_touch_reg <= res_touch_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_p_reg     <= out_p_next;
        out_touch_reg <= out_touch_next;
    end

    // a sample always produces a report, so the sequencer leaves idle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_ch.operation == tpf_pkg::OP_SAMPLE)
        |=> state_reg != tpf_pkg::ST_IDLE)
        else $error("sample accepted but sequencer stayed idle");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpf_pkg::ST_DIVIDE) |-> (rem_reg < z1_reg))
        else $error("divider remainder out of range");

    // a release is only reported after at least one pen-up was counted
    a_release_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        release_reported_reg |-> (penup_cnt_reg != '0))
        else $error("release flag set with zero pen-up count");

    // a finished report lands in the output register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == tpf_pkg::ST_IDLE))
        else $error("finished report not loaded into output register");

endmodule
